// File: src/ntta_pkg.sv
// Shared constants and controller/datapath types for the neighbor table aging unit.
`timescale 1ns / 1ps

package ntta_pkg;

    localparam int ID_W    = 48;
    localparam int FRESH_W = 8;
    localparam int SLOT_W  = 4;
    localparam int OCC_W   = 5;

    localparam logic [FRESH_W-1:0] FRESH_MAX = 8'hFF;

    // Command codes of an input item
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture item, clear scan state
        logic rd;      // issue table read at the scan address
        logic commit;  // final table write, load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_addr;  // scan address is the last entry
    } t_dp_status;

endpackage

// File: src/ntta_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface ntta_in_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [ntta_pkg::ID_W-1:0] node_id;

    modport source (output valid, output cmd, output node_id, input ready);
    modport sink   (input valid, input cmd, input node_id, output ready);
endinterface

interface ntta_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       inserted;
    logic [ntta_pkg::SLOT_W-1:0] slot;
    logic                       evicted_valid;
    logic [ntta_pkg::ID_W-1:0]   evicted_id;
    logic [ntta_pkg::OCC_W-1:0]  occupied_count;

    modport source (output valid, output hit, output inserted, output slot,
                    output evicted_valid, output evicted_id, output occupied_count,
                    input ready);
    modport sink   (input valid, input hit, input inserted, input slot,
                    input evicted_valid, input evicted_id, input occupied_count,
                    output ready);
endinterface

// File: src/ntta_dp.sv
// Datapath: entry memory, scan accumulators, aging write-back and result register.
`timescale 1ns / 1ps

module ntta_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ntta_pkg::t_dp_cmd           i_cmd,
    input  logic                        i_item_cmd,
    input  logic [ntta_pkg::ID_W-1:0]   i_item_id,
    output ntta_pkg::t_dp_status        o_status,
    output logic                        o_hit,
    output logic                        o_inserted,
    output logic [ntta_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_evicted_valid,
    output logic [ntta_pkg::ID_W-1:0]   o_evicted_id,
    output logic [ntta_pkg::OCC_W-1:0]  o_occupied_count
);
    import ntta_pkg::*;

    localparam int IDXW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OCCW    = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + FRESH_W;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_DEPTH - 1);

    // entry word: {node id, freshness}
    logic [ENTRY_W-1:0]     r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_ent_vld;

    logic [IDXW-1:0]    r_rd_addr;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_pv;
    logic [IDXW-1:0]    r_pidx;

    logic [ID_W-1:0]    r_id;
    logic               r_upd;
    logic               r_found;
    logic [IDXW-1:0]    r_found_idx;
    logic               r_has_empty;
    logic [IDXW-1:0]    r_empty_idx;
    logic [OCCW-1:0]    r_occ;
    logic [FRESH_W-1:0] r_min;
    logic [IDXW-1:0]    r_min_idx;
    logic [ID_W-1:0]    r_min_id;

    logic               r_hit;
    logic               r_inserted;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_ev_valid;
    logic [ID_W-1:0]    r_ev_id;
    logic [OCC_W-1:0]   r_occ_out;

    logic [ID_W-1:0]    rd_id;
    logic [FRESH_W-1:0] rd_fr;
    logic [FRESH_W-1:0] rd_dec;
    logic               rd_match;
    logic               rd_empty;
    logic [IDXW-1:0]    tgt_idx;
    logic               wr_en;
    logic [IDXW-1:0]    wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               ins_new;
    logic               ins_evict;

    always_comb begin
        // never-written entries read as empty with zero freshness
        rd_id    = r_rd_vld ? r_rd_data[ENTRY_W-1:FRESH_W] : '0;
        rd_fr    = r_rd_vld ? r_rd_data[FRESH_W-1:0] : '0;
        rd_dec   = (rd_fr != '0) ? rd_fr - FRESH_W'(1) : '0;
        rd_match = (r_id != '0) && (rd_id == r_id);
        rd_empty = (rd_id == '0);

        tgt_idx   = r_found ? r_found_idx : (r_has_empty ? r_empty_idx : r_min_idx);
        ins_new   = r_upd && !r_found && r_has_empty;
        ins_evict = r_upd && !r_found && !r_has_empty;

        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = {rd_id, rd_dec};
        if (i_cmd.commit) begin
            wr_en   = r_upd;
            wr_addr = tgt_idx;
            wr_data = {r_id, FRESH_MAX};
        end else if (r_pv && r_upd && rd_fr != '0) begin
            wr_en = 1'b1;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_addr];
            r_rd_vld  <= r_ent_vld[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (wr_en) begin
            r_ent_vld[wr_addr] <= 1'b1;
        end
    end

    // scan control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr   <= '0;
            r_pv        <= 1'b0;
            r_upd       <= 1'b0;
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
            r_occ       <= '0;
        end else if (i_cmd.load) begin
            r_rd_addr   <= '0;
            r_pv        <= 1'b0;
            r_id        <= i_item_id;
            r_upd       <= (i_item_cmd == CMD_OBSERVE) && (i_item_id != '0);
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
            r_occ       <= '0;
        end else begin
            r_pv <= i_cmd.rd;
            if (i_cmd.rd) begin
                r_rd_addr <= r_rd_addr + IDXW'(1);
                r_pidx    <= r_rd_addr;
            end
            if (r_pv) begin
                if (rd_match && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_pidx;
                end
                if (rd_empty && !r_has_empty) begin
                    r_has_empty <= 1'b1;
                    r_empty_idx <= r_pidx;
                end
                if (!rd_empty) begin
                    r_occ <= r_occ + OCCW'(1);
                end
                // lowest count after aging, first index wins a tie
                if (r_pidx == '0 || rd_dec < r_min) begin
                    r_min     <= rd_dec;
                    r_min_idx <= r_pidx;
                    r_min_id  <= rd_id;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit      <= r_found;
            r_inserted <= r_upd && !r_found;
            r_slot     <= (r_found || r_upd) ? SLOT_W'(tgt_idx) : '0;
            r_ev_valid <= ins_evict;
            r_ev_id    <= ins_evict ? r_min_id : '0;
            r_occ_out  <= ins_new ? OCC_W'(r_occ + OCCW'(1)) : OCC_W'(r_occ);
        end
    end

    assign o_status.last_addr = (r_rd_addr == LAST_IDX);
    assign o_hit              = r_hit;
    assign o_inserted         = r_inserted;
    assign o_slot             = r_slot;
    assign o_evicted_valid    = r_ev_valid;
    assign o_evicted_id       = r_ev_id;
    assign o_occupied_count   = r_occ_out;

`ifndef SYNTHESIS
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_id != '0))
        else $error("match recorded for the empty id");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCCW'(TABLE_DEPTH))
        else $error("occupancy above table depth");

    a_commit_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !i_cmd.rd && !r_pv)
        else $error("final write overlaps the scan");
`endif

endmodule

// File: src/ntta_ctrl.sv
// Controller: item sequencing over scan, drain and commit, plus output valid tracking.
`timescale 1ns / 1ps

module ntta_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ntta_pkg::t_dp_status  i_status,
    output ntta_pkg::t_dp_cmd     o_cmd
);
    import ntta_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_xfer;
    logic   out_free;

    always_comb begin
        in_xfer  = i_in_valid && r_in_ready;
        out_free = !r_out_valid || i_out_ready;

        o_cmd.load   = in_xfer;
        o_cmd.rd     = (r_state == ST_SCAN);
        o_cmd.commit = (r_state == ST_FINAL) && out_free;

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.last_addr) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == ST_IDLE);
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_SCAN) && !o_in_ready)
        else $error("accepted item did not start a scan");
`endif

endmodule

// File: src/neighbor_table_ttl_aging_unit.sv
// Top level of the neighbor table with freshness aging and replacement.
`timescale 1ns / 1ps

// Usage:
//   i_in  : input channel (cmd, node_id). cmd observe refreshes or inserts the
//           id and ages all other entries by one; cmd query only looks it up.
//   o_out : one result per input transfer (hit, inserted, slot, evicted_valid,
//           evicted_id, occupied_count), in input order.
//   Each item walks the whole table through the single read port of the entry
//   memory, one entry per cycle; an observe writes aged counts back behind the
//   read. A new item is taken only once the last one has committed.
//   i_in.ready is high only between items. A finished result sits in the
//   output register; a stalled receiver lets the next item be taken and
//   scanned, and that item waits in its commit step until the register frees.
//   Reset (synchronous, active low) empties the table at once through per-entry
//   valid bits, so no clearing pass is needed, and drops any pending result.

module neighbor_table_ttl_aging_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntta_in_if.sink     i_in,
    ntta_out_if.source  o_out
);
    import ntta_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic       out_valid;

    // sequencing: accept, walk entries, drain the read pipe, commit
    ntta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // table storage, scan accumulators and the result register
    ntta_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_item_cmd       (i_in.cmd),
        .i_item_id        (i_in.node_id),
        .o_status         (dp_status),
        .o_hit            (o_out.hit),
        .o_inserted       (o_out.inserted),
        .o_slot           (o_out.slot),
        .o_evicted_valid  (o_out.evicted_valid),
        .o_evicted_id     (o_out.evicted_id),
        .o_occupied_count (o_out.occupied_count)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// File: verif/neighbor_table_ttl_aging_unit_tb.sv
// Self-checking testbench for the neighbor table aging unit: directed rows, then random traffic.
`timescale 1ns / 1ps

module neighbor_table_ttl_aging_unit_tb;
    import ntta_pkg::*;

    localparam int DEPTH    = 16;
    localparam int POOL_SZ  = 24;         // more ids than slots, so the table churns
    localparam int LATENCY  = DEPTH + 2;  // input transfer to result valid
    localparam int HOLD_LEN = 400;        // long receiver stall, fills the block

    // One result transfer, field for field as on o_out
    typedef struct packed {
        logic                hit;
        logic                inserted;
        logic [SLOT_W-1:0]   slot;
        logic                evicted_valid;
        logic [ID_W-1:0]     evicted_id;
        logic [OCC_W-1:0]    occupied_count;
    } t_nbr_result;

    // Directed stimulus row; lit_res is used only when has_lit is set
    typedef struct {
        logic            cmd;
        logic [ID_W-1:0] id;
        bit              has_lit;
        t_nbr_result     lit_res;
    } t_dir_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ntta_in_if  in_ch ();
    ntta_out_if out_ch ();

    neighbor_table_ttl_aging_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the table, advanced once per accepted input transfer
    logic [ID_W-1:0]    tbl_id    [DEPTH];
    logic [FRESH_W-1:0] tbl_fresh [DEPTH];

    t_nbr_result     results_due [$];   // predicted results, oldest first
    t_dir_row        directed_rows [$];
    logic [ID_W-1:0] id_pool [POOL_SZ];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;  // set by stimulus, picked up by the receiver
    int hold_left     = 0;

    int n_fail   = 0;
    int n_items  = 0;
    int n_query  = 0;
    int n_hit    = 0;
    int n_insert = 0;
    int n_evict  = 0;

    // Table update for one item: lookup; on an observe, aging of all other live counts,
    // then insert into the first empty slot or replace the stalest entry.
    function automatic t_nbr_result table_update(input logic cmd,
                                                 input logic [ID_W-1:0] id);
        t_nbr_result r;
        int found;
        int target;
        int occ;
        r     = '0;
        found = -1;
        if (id != '0) begin
            for (int i = 0; i < DEPTH; i++)
                if (found < 0 && tbl_id[i] == id) found = i;
        end
        if (found >= 0) begin
            r.hit  = 1'b1;
            r.slot = found[SLOT_W-1:0];
        end
        // observe of id zero is a no-op on the table
        if (cmd == CMD_OBSERVE && id != '0) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i == found)
                    tbl_fresh[i] = FRESH_MAX;
                else if (tbl_fresh[i] != '0)
                    tbl_fresh[i] = tbl_fresh[i] - 1'b1;
            end
            if (found < 0) begin
                target = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (target < 0 && tbl_id[i] == '0) target = i;
                if (target < 0) begin
                    // full: lowest count after aging, lowest index wins a tie
                    target = 0;
                    for (int i = 1; i < DEPTH; i++)
                        if (tbl_fresh[i] < tbl_fresh[target]) target = i;
                    r.evicted_valid = 1'b1;
                    r.evicted_id    = tbl_id[target];
                end
                tbl_id[target]    = id;
                tbl_fresh[target] = FRESH_MAX;
                r.inserted        = 1'b1;
                r.slot            = target[SLOT_W-1:0];
            end
        end
        occ = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_id[i] != '0) occ++;
        r.occupied_count = occ[OCC_W-1:0];
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'({$urandom(), $urandom()});
    endfunction

    function automatic void add_row(input logic cmd, input logic [ID_W-1:0] id,
                                    input bit has_lit, input logic hit,
                                    input logic ins, input int slot,
                                    input logic ev_v, input logic [ID_W-1:0] ev_id,
                                    input int occ);
        t_dir_row row;
        row.cmd                    = cmd;
        row.id                     = id;
        row.has_lit                = has_lit;
        row.lit_res.hit            = hit;
        row.lit_res.inserted       = ins;
        row.lit_res.slot           = slot[SLOT_W-1:0];
        row.lit_res.evicted_valid  = ev_v;
        row.lit_res.evicted_id     = ev_id;
        row.lit_res.occupied_count = occ[OCC_W-1:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                        input logic [ID_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Offer one item and hold it until the block takes it. valid stays high
    // between back-to-back items; each idle cycle before an item lowers it.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input bit has_lit, input t_nbr_result lit_res);
        t_nbr_result r;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.node_id <= id;
        do @(posedge clk); while (!in_ch.ready);
        r = table_update(cmd, id);
        if (has_lit) r = lit_res;
        results_due.push_back(r);
        n_items++;
        if (cmd == CMD_QUERY) n_query++;
        if (r.hit) n_hit++;
        if (r.inserted) n_insert++;
        if (r.evicted_valid) n_evict++;
    endtask

    // Sender pause: drop valid and let every outstanding result come back
    task automatic wait_drained(input int max_cycles);
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0 && n < max_cycles) begin
            @(posedge clk);
            n++;
        end
    endtask

    // Fill-then-starve pattern: one resident id is observed far past 255
    // times so every other count bottoms out at zero, then new ids force
    // replacements among entries tied at zero.
    task automatic hammer_one_id();
        logic [ID_W-1:0] keep;
        keep = tbl_id[$urandom_range(DEPTH-1)];
        for (int k = 0; k < 300; k++) begin
            if ($urandom_range(9) == 0)
                send_item(CMD_QUERY, id_pool[$urandom_range(POOL_SZ-1)], 1'b0, '0);
            else
                send_item(CMD_OBSERVE, keep, 1'b0, '0);
        end
        for (int k = 0; k < 4; k++)
            send_item(CMD_OBSERVE, rand_id(), 1'b0, '0);
    endtask

    // Random traffic: mostly ids from a small pool (hits, refreshes, churn),
    // some fresh ids, and the zero and all-ones ids now and then.
    task automatic random_phase(input int s_pct, input int r_pct, input int n,
                                input int hold_at, input int pause_at,
                                input int hammer_at);
        logic            cmd;
        logic [ID_W-1:0] id;
        int              roll;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_req = HOLD_LEN;
            if (k == pause_at) wait_drained(100000);
            if (k == hammer_at) hammer_one_id();
            cmd  = ($urandom_range(99) < 25) ? CMD_QUERY : CMD_OBSERVE;
            roll = $urandom_range(99);
            if (roll < 70)      id = id_pool[$urandom_range(POOL_SZ-1)];
            else if (roll < 90) id = rand_id();
            else if (roll < 95) id = '0;
            else                id = '1;
            send_item(cmd, id, 1'b0, '0);
        end
    endtask

    // Receiver: random ready, long hold-off on request, result checking.
    // Outputs are sampled as they stood before the edge.
    always @(posedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (results_due.size() == 0) begin
                $error("result transfer with nothing outstanding");
                n_fail++;
            end else begin
                t_nbr_result want;
                want = results_due.pop_front();
                check_field("hit", want.hit, out_ch.hit);
                check_field("inserted", want.inserted, out_ch.inserted);
                check_field("slot", want.slot, out_ch.slot);
                check_field("evicted_valid", want.evicted_valid, out_ch.evicted_valid);
                check_field("evicted_id", want.evicted_id, out_ch.evicted_id);
                check_field("occupied_count", want.occupied_count,
                            out_ch.occupied_count);
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_OBSERVE;
        in_ch.node_id = '0;
        out_ch.ready  = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_id[i]    = '0;
            tbl_fresh[i] = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: cmd, id, literal?, hit, inserted, slot, ev_valid, ev_id, occ
        add_row(CMD_QUERY,   '0, 1, 0, 0, 0, 0, '0, 0);  // empty table, zero id
        add_row(CMD_QUERY,   '1, 1, 0, 0, 0, 0, '0, 0);  // query miss
        add_row(CMD_OBSERVE, '0, 1, 0, 0, 0, 0, '0, 0);  // observe zero ignored
        add_row(CMD_OBSERVE, '1, 1, 0, 1, 0, 0, '0, 1);  // first insert
        add_row(CMD_OBSERVE, 48'h1, 1, 0, 1, 1, 0, '0, 2);
        add_row(CMD_QUERY,   '1, 1, 1, 0, 0, 0, '0, 2);
        add_row(CMD_QUERY,   48'h1, 1, 1, 0, 1, 0, '0, 2);
        add_row(CMD_OBSERVE, '0, 1, 0, 0, 0, 0, '0, 2);  // ignored, table kept
        add_row(CMD_QUERY,   '0, 1, 0, 0, 0, 0, '0, 2);  // zero never hits an empty slot
        add_row(CMD_OBSERVE, '1, 1, 1, 0, 0, 0, '0, 2);  // refresh on hit
        add_row(CMD_OBSERVE, 48'h5555_5555_5555, 0, 0, 0, 0, 0, '0, 0);
        add_row(CMD_OBSERVE, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, 0, '0, 0);
        add_row(CMD_OBSERVE, 48'h8000_0000_0000, 0, 0, 0, 0, 0, '0, 0);
        add_row(CMD_OBSERVE, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0, '0, 0);
        for (int k = 0; k < 10; k++)
            add_row(CMD_OBSERVE, 48'h0123_4567_8900 + ID_W'(k), 0, 0, 0, 0, 0, '0, 0);
        add_row(CMD_OBSERVE, 48'h2, 0, 0, 0, 0, 0, '0, 0);  // full table, replacement

        foreach (directed_rows[k])
            send_item(directed_rows[k].cmd, directed_rows[k].id,
                      directed_rows[k].has_lit, directed_rows[k].lit_res);
        wait_drained(100000);

        for (int k = 0; k < POOL_SZ; k++)
            id_pool[k] = rand_id();

        // Three idling regimes; long receiver hold-off in the first,
        // full sender pause in the second, zero-count ties in the last.
        random_phase(21, 47, 460, 200, -1, -1);
        random_phase(47, 21, 460, -1, 230, -1);
        random_phase(0, 0, 460, -1, -1, 100);

        wait_drained(20000);
        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            n_fail++;
        end
        repeat (LATENCY + 20) @(posedge clk);

        $display("Ran %0d items (%0d queries): %0d hits, %0d inserts, %0d replacements,",
                 n_items, n_query, n_hit, n_insert, n_evict);
        $display("under three stall mixes, a long output hold-off and zero-count ties.");
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
